### hw/rtl/slbm_pkg.sv
// Shared types, constants and palette lookup for the sound level bar meter.
package slbm_pkg;

   // Sample and level widths
   localparam int SAMPLE_W = 10;
   localparam int LEVEL_W  = 5;
   localparam int INDEX_W  = 4;
   localparam int COLOR_W  = 24;
   localparam int PROD_W   = 17;

   // Level scaling: level = peak_to_peak * LEVEL_GAIN / LEVEL_STEP
   localparam logic [PROD_W-1:0] LEVEL_GAIN = 17'd125;
   localparam logic [PROD_W-1:0] LEVEL_STEP = 17'd8448;
   localparam int                LEVEL_CEIL = 15;

   // Empty-window reset values
   localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;
   localparam logic [SAMPLE_W:0]   MIN_RESET = 11'd1024;

   // Run queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_COLOR    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_MODE = 4'd1;

   // Fixed palette bands
   localparam logic [COLOR_W-1:0] BAND0_COLOR = {8'd255, 8'd202, 8'd51};
   localparam logic [COLOR_W-1:0] BAND1_COLOR = {8'd66,  8'd193, 8'd1};
   localparam logic [COLOR_W-1:0] BAND2_COLOR = {8'd6,   8'd215, 8'd223};
   localparam logic [COLOR_W-1:0] BAND3_COLOR = {8'd194, 8'd6,   8'd223};
   localparam logic [COLOR_W-1:0] BAND4_COLOR = {8'd223, 8'd6,   8'd6};
   localparam logic [COLOR_W-1:0] BLANK_COLOR = '0;

   // One pixel write run handed from front to back
   typedef struct packed {
      logic               light;
      logic [INDEX_W-1:0] first_idx;
      logic [INDEX_W-1:0] final_idx;
   } run_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [COLOR_W-1:0] bar_color;
      logic               palette_mode;
   } cfg_type;

   // Queue status toward the front end
   typedef struct packed {
      logic full;
      logic avail;
   } queue_status_type;

   function automatic logic [COLOR_W-1:0] palette_color(input logic [INDEX_W-1:0] idx);
      logic [COLOR_W-1:0] color;
      if (idx < 4'd3)       color = BAND0_COLOR;
      else if (idx < 4'd5)  color = BAND1_COLOR;
      else if (idx < 4'd7)  color = BAND2_COLOR;
      else if (idx < 4'd10) color = BAND3_COLOR;
      else                  color = BAND4_COLOR;
      return color;
   endfunction

endpackage

### hw/rtl/sound_level_bar_meter_core.sv
// Sound level bar meter top level: config registers, front end, run queue, back end.
//
// Usage:
//   req_*  carries one microphone sample per item; req_window_end marks the
//          last sample of a measurement window. The item is taken when
//          req_valid is high and req_stall low.
//   rsp_*  carries pixel writes (index, red, green, blue, last). rsp_last
//          flags the final write of a window's run.
//   csr_*  writes bar_color (index 0) and palette_mode (index 1); csr_ready
//          is always high.
// Flow: a mid-window sample is taken whenever req_stall is low. A window-end
//   sample is tracked, then levelled and classified in the front end; req_stall
//   is high during the level step. The back end fetches a run, then emits one
//   write per cycle while rsp_stall is low. The two-entry run queue lets the
//   next window fill meanwhile; input also stalls when the queue is full.
// Path: a run goes from the window-end item through the pending flag, the run
//   queue, the back-end run registers and the output register.
// Reset clears the window, previous level, queue and registers. A stalled
//   receiver holds the current write steady and pauses the run walk.
module sound_level_bar_meter_core #(
   parameter int NUM_PIXELS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [slbm_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                req_window_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [slbm_pkg::INDEX_W-1:0]        rsp_pixel_index,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slbm_pkg::COLOR_W-1:0]        csr_wdata
);

   slbm_pkg::cfg_type           cfg_ff, cfg_in;
   slbm_pkg::run_type           push_run;
   slbm_pkg::run_type           head_run;
   slbm_pkg::queue_status_type  qstat;
   logic                        push;
   logic                        pop;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            slbm_pkg::CSR_BAR_COLOR:    cfg_in.bar_color    = csr_wdata;
            slbm_pkg::CSR_PALETTE_MODE: cfg_in.palette_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slbm_front #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_window_end (req_window_end),
      .queue_full     (qstat.full),
      .push           (push),
      .push_run       (push_run)
   );

   slbm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head_run (head_run),
      .status   (qstat)
   );

   slbm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .run_avail       (qstat.avail),
      .head_run        (head_run),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // A closed window blocks input for the level cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_window_end |=> req_stall)
      else $error("input taken while closing a window");

   // The front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("run pushed into full queue");

   // Writes of a run follow each other without gaps once taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a pixel run");

   // No run is fetched while the back end is still walking one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !pop)
      else $error("run fetched before previous run ended");
`endif

endmodule

### hw/rtl/slbm_front.sv
// Front end: window min/max tracking, bar level and run classification.
module slbm_front #(
   parameter int NUM_PIXELS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [slbm_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              req_window_end,
   input  logic                              queue_full,
   output logic                              push,
   output slbm_pkg::run_type                 push_run
);

   // Highest level and highest on-strip index that fit the 4-bit index range
   localparam int LVL_MAX = (NUM_PIXELS < slbm_pkg::LEVEL_CEIL) ?
                            NUM_PIXELS : slbm_pkg::LEVEL_CEIL;
   localparam int TOP_MAX = (NUM_PIXELS - 1 < slbm_pkg::LEVEL_CEIL) ?
                            NUM_PIXELS - 1 : slbm_pkg::LEVEL_CEIL;
   localparam logic [slbm_pkg::LEVEL_W-1:0] LVL_SAT = slbm_pkg::LEVEL_W'(LVL_MAX);
   localparam logic [slbm_pkg::LEVEL_W-1:0] TOP_IDX = slbm_pkg::LEVEL_W'(TOP_MAX);

   logic [slbm_pkg::SAMPLE_W-1:0]   max_ff, max_in;
   logic [slbm_pkg::SAMPLE_W:0]     min_ff, min_in;
   logic [slbm_pkg::LEVEL_W-1:0]    prev_ff, prev_in;
   logic                            pend_ff, pend_in;

   logic                            accept;
   logic [slbm_pkg::SAMPLE_W:0]     sample_ext;
   logic [slbm_pkg::SAMPLE_W-1:0]   p2p;
   logic [slbm_pkg::PROD_W-1:0]     prod;
   logic [slbm_pkg::LEVEL_CEIL-1:0] over;
   logic [slbm_pkg::LEVEL_W-1:0]    level_raw;
   logic [slbm_pkg::LEVEL_W-1:0]    level;
   logic [slbm_pkg::LEVEL_W-1:0]    blank_top;
   logic [slbm_pkg::LEVEL_W-1:0]    level_dec;
   logic [slbm_pkg::LEVEL_W-1:0]    level_inc;

   // Hold input while the level of a closed window is pending or the queue is full
   assign req_stall  = pend_ff | queue_full;
   assign accept     = req_valid & ~req_stall;
   assign sample_ext = {1'b0, req_sample};

   // Peak-to-peak, scaled and compared against each level threshold
   always_comb begin
      if ({1'b0, max_ff} >= min_ff) begin
         p2p = max_ff - min_ff[slbm_pkg::SAMPLE_W-1:0];
      end else begin
         p2p = '0;
      end
      prod = slbm_pkg::PROD_W'(p2p) * slbm_pkg::LEVEL_GAIN;
      for (int k = 0; k < slbm_pkg::LEVEL_CEIL; k++) begin
         over[k] = prod >= slbm_pkg::PROD_W'((k + 1) * slbm_pkg::LEVEL_STEP);
      end
      level_raw = slbm_pkg::LEVEL_W'($countones(over));
      level     = (level_raw > LVL_SAT) ? LVL_SAT : level_raw;
      blank_top = (prev_ff > TOP_IDX) ? TOP_IDX : prev_ff;
      level_dec = level - 5'd1;
      level_inc = level + 5'd1;
   end

   // Track the window and close it once it is pending and the queue has room
   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      prev_in  = prev_ff;
      pend_in  = pend_ff;
      push     = 1'b0;
      push_run = '0;
      if (accept) begin
         if (req_sample > max_ff) max_in = req_sample;
         if (sample_ext < min_ff) min_in = sample_ext;
         pend_in = req_window_end;
      end
      if (pend_ff && !queue_full) begin
         if (level > prev_ff) begin
            push               = 1'b1;
            push_run.light     = 1'b1;
            push_run.first_idx = '0;
            push_run.final_idx = level_dec[slbm_pkg::INDEX_W-1:0];
         end else begin
            push               = blank_top > level;
            push_run.light     = 1'b0;
            push_run.first_idx = blank_top[slbm_pkg::INDEX_W-1:0];
            push_run.final_idx = level_inc[slbm_pkg::INDEX_W-1:0];
         end
         max_in  = slbm_pkg::MAX_RESET;
         min_in  = slbm_pkg::MIN_RESET;
         prev_in = level;
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= slbm_pkg::MAX_RESET;
         min_ff  <= slbm_pkg::MIN_RESET;
         prev_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         prev_ff <= prev_in;
         pend_ff <= pend_in;
      end
   end

endmodule

### hw/rtl/slbm_queue.sv
// Short run queue between the front and back ends.
module slbm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  slbm_pkg::run_type            push_run,
   input  logic                         pop,
   output slbm_pkg::run_type            head_run,
   output slbm_pkg::queue_status_type   status
);

   localparam logic [slbm_pkg::QPTR_W:0] DEPTH_CNT = (slbm_pkg::QPTR_W + 1)'(slbm_pkg::QUEUE_DEPTH);
   localparam logic [slbm_pkg::QPTR_W-1:0] LAST_PTR =
      slbm_pkg::QPTR_W'(slbm_pkg::QUEUE_DEPTH - 1);

   slbm_pkg::run_type            mem_ff [slbm_pkg::QUEUE_DEPTH];
   logic [slbm_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [slbm_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [slbm_pkg::QPTR_W:0]    count_ff, count_in;
   logic                         do_push, do_pop;

   assign status.full  = count_ff == DEPTH_CNT;
   assign status.avail = count_ff != '0;
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & status.avail;
   assign head_run     = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_run;
   end

endmodule

### hw/rtl/slbm_back.sv
// Back end: walks one run and emits its pixel writes through an output register.
module slbm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  slbm_pkg::cfg_type             cfg,
   input  logic                          run_avail,
   input  slbm_pkg::run_type             head_run,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [slbm_pkg::INDEX_W-1:0]  rsp_pixel_index,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   output logic                          rsp_last
);

   logic                          busy_ff, busy_in;
   logic                          light_ff, light_in;
   logic [slbm_pkg::INDEX_W-1:0]  cur_ff, cur_in;
   logic [slbm_pkg::INDEX_W-1:0]  fin_ff, fin_in;
   logic                          out_valid_ff, out_valid_in;
   logic [slbm_pkg::INDEX_W-1:0]  out_idx_ff, out_idx_in;
   logic [slbm_pkg::COLOR_W-1:0]  out_color_ff, out_color_in;
   logic                          out_last_ff, out_last_in;
   logic                          load_out;
   logic                          at_final;
   logic [slbm_pkg::COLOR_W-1:0]  lit_color;

   assign pop      = ~busy_ff & run_avail;
   assign load_out = busy_ff & (~out_valid_ff | ~rsp_stall);
   assign at_final = cur_ff == fin_ff;
   assign lit_color = cfg.palette_mode ? slbm_pkg::palette_color(cur_ff) : cfg.bar_color;

   // Step through the run, one write per free output slot
   always_comb begin
      busy_in      = busy_ff;
      light_in     = light_ff;
      cur_in       = cur_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_idx_in   = cur_ff;
         out_color_in = light_ff ? lit_color : slbm_pkg::BLANK_COLOR;
         out_last_in  = at_final;
         cur_in       = light_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
         if (at_final) busy_in = 1'b0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in  = 1'b1;
         light_in = head_run.light;
         cur_in   = head_run.first_idx;
         fin_in   = head_run.final_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      light_ff     <= light_in;
      cur_ff       <= cur_in;
      fin_ff       <= fin_in;
      out_idx_ff   <= out_idx_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_red         = out_color_ff[23:16];
   assign rsp_green       = out_color_ff[15:8];
   assign rsp_blue        = out_color_ff[7:0];
   assign rsp_last        = out_last_ff;

endmodule

### tb/sv/sound_level_bar_meter_core_tb.sv
// Self-checking testbench for the sound level bar meter core.
module sound_level_bar_meter_core_tb;

   localparam int NUM_PIXELS     = 15;
   localparam int SETTLE_CYCLES  = 32;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   // Index with no register behind it; a write there must change nothing
   localparam logic [slbm_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'hF;

   // One pixel write as seen on the result channel
   typedef struct packed {
      logic [slbm_pkg::INDEX_W-1:0] index;
      logic [7:0]                   red;
      logic [7:0]                   green;
      logic [7:0]                   blue;
      logic                         last;
   } pixel_write_type;

   // Tracks the window, predicts each run of pixel writes and checks them in order
   class pixel_write_scoreboard #(int PIXELS = 15);
      logic [slbm_pkg::SAMPLE_W-1:0] win_max;
      logic [slbm_pkg::SAMPLE_W:0]   win_min;
      logic [slbm_pkg::LEVEL_W-1:0]  prev_level;
      logic [slbm_pkg::COLOR_W-1:0]  bar_color;
      logic                          palette_mode;
      pixel_write_type               expected_writes[$];
      int                            errors;

      function new();
         win_max      = slbm_pkg::MAX_RESET;
         win_min      = slbm_pkg::MIN_RESET;
         prev_level   = '0;
         bar_color    = '0;
         palette_mode = 1'b0;
         errors       = 0;
      endfunction

      function void set_reg(input logic [slbm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [slbm_pkg::COLOR_W-1:0] data);
         if (idx == slbm_pkg::CSR_BAR_COLOR) bar_color = data;
         else if (idx == slbm_pkg::CSR_PALETTE_MODE) palette_mode = data[0];
      endfunction

      // Five fixed bands along the strip
      function logic [slbm_pkg::COLOR_W-1:0] band_rgb(input int pix);
         logic [slbm_pkg::COLOR_W-1:0] rgb;
         if (pix < 3)       rgb = {8'd255, 8'd202, 8'd51};
         else if (pix < 5)  rgb = {8'd66, 8'd193, 8'd1};
         else if (pix < 7)  rgb = {8'd6, 8'd215, 8'd223};
         else if (pix < 10) rgb = {8'd194, 8'd6, 8'd223};
         else               rgb = {8'd223, 8'd6, 8'd6};
         return rgb;
      endfunction

      // Update the window; on its last sample queue the writes it causes
      function void note_sample(input logic [slbm_pkg::SAMPLE_W-1:0] smp, input logic win_end);
         int p2p;
         int lvl;
         int pix;
         int n;
         logic [slbm_pkg::COLOR_W-1:0] rgb;
         pixel_write_type w;
         if (smp > win_max) win_max = smp;
         if ({1'b0, smp} < win_min) win_min = {1'b0, smp};
         if (!win_end) return;
         lvl = 0;
         n = 0;
         if ({1'b0, win_max} >= win_min) begin
            p2p = int'(win_max) - int'(win_min);
            lvl = p2p * 125 / 8448;
         end
         if (lvl > PIXELS) lvl = PIXELS;
         if (lvl <= int'(prev_level)) begin
            // blank from the old level down, skipping pixels past the strip
            for (pix = int'(prev_level); pix > lvl; pix--) begin
               if (pix < PIXELS) begin
                  w.index = 4'(pix);
                  w.red   = 8'd0;
                  w.green = 8'd0;
                  w.blue  = 8'd0;
                  w.last  = 1'b0;
                  expected_writes.push_back(w);
                  n++;
               end
            end
         end else begin
            // light the bar from pixel zero up
            for (pix = 0; pix < lvl; pix++) begin
               rgb     = palette_mode ? band_rgb(pix) : bar_color;
               w.index = 4'(pix);
               w.red   = rgb[23:16];
               w.green = rgb[15:8];
               w.blue  = rgb[7:0];
               w.last  = 1'b0;
               expected_writes.push_back(w);
               n++;
            end
         end
         if (n > 0) begin
            w = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
         end
         prev_level = 5'(lvl);
         win_max    = slbm_pkg::MAX_RESET;
         win_min    = slbm_pkg::MIN_RESET;
      endfunction

      // Compare one accepted write with the oldest expectation
      function void check_write(input logic [slbm_pkg::INDEX_W-1:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b, input logic lst);
         pixel_write_type w;
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write index %0d rgb %0d,%0d,%0d last %0b",
                     $time, idx, r, g, b, lst);
            errors++;
            return;
         end
         w = expected_writes.pop_front();
         if (idx !== w.index) begin
            $display("%0t: pixel_index expected %0d actual %0d", $time, w.index, idx);
            errors++;
         end
         if (r !== w.red) begin
            $display("%0t: red expected %0d actual %0d", $time, w.red, r);
            errors++;
         end
         if (g !== w.green) begin
            $display("%0t: green expected %0d actual %0d", $time, w.green, g);
            errors++;
         end
         if (b !== w.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, w.blue, b);
            errors++;
         end
         if (lst !== w.last) begin
            $display("%0t: last expected %0b actual %0b", $time, w.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [slbm_pkg::SAMPLE_W-1:0]    req_sample;
   logic                             req_window_end;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [slbm_pkg::INDEX_W-1:0]     rsp_pixel_index;
   logic [7:0]                       rsp_red;
   logic [7:0]                       rsp_green;
   logic [7:0]                       rsp_blue;
   logic                             rsp_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [slbm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [slbm_pkg::COLOR_W-1:0]     csr_wdata;

   pixel_write_scoreboard #(NUM_PIXELS) sb;

   // Shared between the stimulus and the write sink
   bit no_idle       = 1'b0;
   bit long_hold_req = 1'b0;

   sound_level_bar_meter_core #(
      .NUM_PIXELS(NUM_PIXELS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_window_end  (req_window_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Offer one sample, idling first at random, and hold it until taken
   task automatic send_item(input logic [slbm_pkg::SAMPLE_W-1:0] smp, input logic win_end);
      int gap;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= smp;
      req_window_end <= win_end;
      do @(posedge clock); while (req_stall);
      sb.note_sample(smp, win_end);
   endtask

   // Stop offering, wait out every expected write, then let the back end go quiet
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; upper palette bits carry noise
   task automatic write_regs(input logic [slbm_pkg::COLOR_W-1:0] color, input logic mode);
      logic [slbm_pkg::COLOR_W-1:0] mode_word;
      mode_word  = {23'($urandom), mode};
      csr_valid <= 1'b1;
      csr_index <= slbm_pkg::CSR_BAR_COLOR;
      csr_wdata <= color;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(slbm_pkg::CSR_BAR_COLOR, color);
      csr_index <= slbm_pkg::CSR_PALETTE_MODE;
      csr_wdata <= mode_word;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(slbm_pkg::CSR_PALETTE_MODE, mode_word);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed windows of random swing, some loose samples as noise
   task automatic run_random(input int n_items);
      int sent;
      int len;
      int amp;
      int lo;
      int k;
      logic [slbm_pkg::SAMPLE_W-1:0] smp;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 6) == 0) begin
            send_item(10'($urandom), 1'($urandom));
            sent++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            amp = ($urandom_range(0, 5) == 0) ? 1023 : $urandom_range(0, 1023);
            lo  = $urandom_range(0, 1023 - amp);
            for (k = 0; k < len; k++) begin
               case ($urandom_range(0, 3))
                  0:       smp = 10'(lo);
                  1:       smp = 10'(lo + amp);
                  default: smp = 10'(lo + $urandom_range(0, amp));
               endcase
               send_item(smp, k == len - 1);
            end
            sent += len;
         end
      end
   endtask

   // Write sink: check accepted writes, stall in bursts or on a long hold request
   initial begin : write_sink
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_write(rsp_pixel_index, rsp_red, rsp_green, rsp_blue, rsp_last);
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) rsp_stall <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
            rsp_stall    <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            hold_left  = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
   end

   // Main stimulus
   initial begin : stimulus
      int w;
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_sample     <= '0;
      req_window_end <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= slbm_pkg::CSR_BAR_COLOR;
      csr_wdata      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full white bar, then the drop, no-change and off-strip cases
      write_regs(24'hFFFFFF, 1'b0);
      send_item(10'd0, 1'b0);      // full swing lights the whole strip
      send_item(10'd1023, 1'b1);
      send_item(10'd1013, 1'b0);   // one step down reaches only the pixel past the strip: no writes
      send_item(10'd0, 1'b1);
      send_item(10'd1023, 1'b0);   // back to full, with a sample inside the range
      send_item(10'd0, 1'b0);
      send_item(10'd600, 1'b1);
      send_item(10'd5, 1'b0);      // smallest swing that still saturates: no change
      send_item(10'd1019, 1'b1);
      send_item(10'd512, 1'b1);    // single-sample window blanks the bar down to pixel one
      send_item(10'd300, 1'b0);    // smallest swing for level one
      send_item(10'd368, 1'b1);
      send_item(10'd700, 1'b0);    // one below it falls back to zero
      send_item(10'd767, 1'b1);
      send_item(10'd1023, 1'b1);   // zero stays zero: no writes
      drain_and_settle();

      // Unmapped index, then palette mode with a black bar colour
      csr_valid <= 1'b1;
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= 24'($urandom);
      do @(posedge clock); while (!csr_ready);
      write_regs(24'h000000, 1'b1);
      send_item(10'd1023, 1'b0);
      send_item(10'd0, 1'b1);
      send_item(10'd0, 1'b0);
      send_item(10'd0, 1'b1);
      send_item(10'd100, 1'b0);
      send_item(10'd438, 1'b1);
      send_item(10'd0, 1'b0);
      send_item(10'd1023, 1'b0);
      send_item(10'd511, 1'b1);
      drain_and_settle();

      // Random phases over several register settings
      write_regs(24'($urandom), 1'b0);
      run_random(70);
      drain_and_settle();

      write_regs(24'h000000, 1'b0);
      run_random(70);
      drain_and_settle();

      // Hold the sink off while full and empty bars pile up behind it
      long_hold_req = 1'b1;
      for (w = 0; w < 16; w++) begin
         if (w % 2 == 0) begin
            send_item(10'd0, 1'b0);
            send_item(10'd1023, 1'b1);
         end else begin
            send_item(10'd512, 1'b1);
         end
      end
      drain_and_settle();

      write_regs(24'($urandom), 1'b1);
      run_random(70);
      drain_and_settle();

      write_regs(24'hFFFFFF, 1'b1);
      run_random(50);
      drain_and_settle();

      // Last phase runs with no idling on either side
      no_idle = 1'b1;
      write_regs(24'($urandom), 1'($urandom));
      run_random(60);
      drain_and_settle();

      if (sb.expected_writes.size() != 0) begin
         $display("%0t: %0d expected writes never arrived", $time, sb.expected_writes.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/slbm_pkg.sv
hw/rtl/slbm_front.sv
hw/rtl/slbm_queue.sv
hw/rtl/slbm_back.sv
hw/rtl/sound_level_bar_meter_core.sv
tb/sv/sound_level_bar_meter_core_tb.sv
